// ===== hw/rtl/tcp_probe_frame_builder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the TCP probe frame builder
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TCP_PROBE_FRAME_BUILDER_ASSERT_SVH
`define TCP_PROBE_FRAME_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TPFB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcp_probe_frame_builder: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcp_probe_frame_builder: assertion failed");

`else

`define TPFB_ASSERT_SAME(label, ante, cons)
`define TPFB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/tpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfb_pkg
// Shared types and protocol constants of the TCP probe frame builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpfb_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        CFG_OWN_MAC      = 2'd0,
        CFG_NEXT_HOP_MAC = 2'd1,
        CFG_OWN_IP       = 2'd2
    } t_cfg_idx;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 64;

    // Protocol constants.
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] IP_LEN_PLAIN   = 16'd40;
    localparam logic [15:0] IP_LEN_SYN     = 16'd44;
    localparam logic [15:0] TCP_LEN_PLAIN  = 16'd20;
    localparam logic [15:0] TCP_LEN_SYN    = 16'd24;
    localparam logic [31:0] TCP_SEQ        = 32'd100;
    localparam logic [15:0] TCP_WINDOW     = 16'd64240;
    localparam logic [3:0]  DOFF_PLAIN     = 4'd5;
    localparam logic [3:0]  DOFF_SYN       = 4'd6;
    localparam logic [15:0] MSS_KIND_LEN   = 16'h0204;
    localparam logic [15:0] TCP_MSS        = 16'd1460;
    localparam int unsigned FLAG_SYN_BIT   = 1;

    // Word position of the final beat of a frame.
    localparam logic [3:0]  LAST_WORD      = 4'd14;

    typedef struct packed {
        logic [47:0] own_mac;
        logic [47:0] next_hop_mac;
        logic [31:0] own_ip;
    } t_cfg;

    typedef struct packed {
        logic [31:0] target_ip;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [5:0]  flag_bits;
    } t_probe;

    typedef struct packed {
        t_probe      probe;
        logic [15:0] ip_csum;
        logic [15:0] tcp_csum;
    } t_frame;

endpackage

`default_nettype wire

// ===== hw/rtl/tpfb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tpfb_cfg_regs
// APB register file holding both MAC addresses and the source IP address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpfb_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tpfb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tpfb_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tpfb_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output tpfb_pkg::t_cfg                     o_cfg
);

    logic [47:0] r_own_mac, n_own_mac;
    logic [47:0] r_next_hop_mac, n_next_hop_mac;
    logic [31:0] r_own_ip, n_own_ip;
    logic        wr_en;
    tpfb_pkg::t_cfg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    // Registers sit on 8-byte boundaries; the low address bits are ignored.
    assign idx    = tpfb_pkg::t_cfg_idx'(paddr[4:3]);

    // Write decode.
    always_comb begin
        n_own_mac      = r_own_mac;
        n_next_hop_mac = r_next_hop_mac;
        n_own_ip       = r_own_ip;
        if (wr_en) begin
            unique case (idx)
                tpfb_pkg::CFG_OWN_MAC:      n_own_mac      = pwdata[47:0];
                tpfb_pkg::CFG_NEXT_HOP_MAC: n_next_hop_mac = pwdata[47:0];
                tpfb_pkg::CFG_OWN_IP:       n_own_ip       = pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Read decode.
    always_comb begin
        unique case (idx)
            tpfb_pkg::CFG_OWN_MAC:      prdata = {16'h0000, r_own_mac};
            tpfb_pkg::CFG_NEXT_HOP_MAC: prdata = {16'h0000, r_next_hop_mac};
            tpfb_pkg::CFG_OWN_IP:       prdata = {32'h0000_0000, r_own_ip};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac      <= '0;
            r_next_hop_mac <= '0;
            r_own_ip       <= '0;
        end else begin
            r_own_mac      <= n_own_mac;
            r_next_hop_mac <= n_next_hop_mac;
            r_own_ip       <= n_own_ip;
        end
    end

    assign o_cfg.own_mac      = r_own_mac;
    assign o_cfg.next_hop_mac = r_next_hop_mac;
    assign o_cfg.own_ip       = r_own_ip;

endmodule

`default_nettype wire

// ===== hw/rtl/tpfb_csum_pipe.sv =====
// ----------------------------------------------------------------------------
// tpfb_csum_pipe
// Three-stage pipeline that computes the IPv4 header and TCP checksums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_probe_frame_builder_assert.svh"

module tpfb_csum_pipe (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [31:0]      i_own_ip,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire tpfb_pkg::t_probe i_probe,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tpfb_pkg::t_frame      o_frame
);

    // Stage registers; valid bits travel with the data.
    logic             r_v1, r_v2, r_v3;
    tpfb_pkg::t_probe r_p1, r_p2;
    tpfb_pkg::t_frame r_s3;
    logic [17:0]      r_addr_sum;
    logic [16:0]      r_port_sum;
    logic [15:0]      r_ip_fixed;
    logic [16:0]      r_tcp_fixed;
    logic [19:0]      r_ip_sum, r_tcp_sum;

    logic             adv1, adv2, adv3;
    logic             syn_in;
    logic [17:0]      n_addr_sum;
    logic [16:0]      n_port_sum;
    logic [15:0]      n_ip_fixed;
    logic [16:0]      n_tcp_fixed;
    logic [19:0]      n_ip_sum, n_tcp_sum;

    // One's-complement fold of a 20-bit sum, then inversion.
    function automatic logic [15:0] f_fold_not(input logic [19:0] s);
        logic [16:0] f1;
        logic [15:0] f2;
        f1 = {1'b0, s[15:0]} + {13'h0000, s[19:16]};
        f2 = f1[15:0] + {15'h0000, f1[16]};
        return ~f2;
    endfunction

    // A stage moves when it is empty or the stage after it moves.
    assign adv3       = !r_v3 || i_out_ready;
    assign adv2       = !r_v2 || adv3;
    assign adv1       = !r_v1 || adv2;
    assign o_in_ready = adv1;

    // Stage 1: address and port partial sums, plus the constant terms.
    always_comb begin
        syn_in     = i_probe.flag_bits[tpfb_pkg::FLAG_SYN_BIT];
        n_addr_sum = {2'b00, i_own_ip[31:16]} + {2'b00, i_own_ip[15:0]}
                   + {2'b00, i_probe.target_ip[31:16]} + {2'b00, i_probe.target_ip[15:0]};
        n_port_sum = {1'b0, i_probe.local_port} + {1'b0, i_probe.remote_port};
        // Version/IHL with TOS, TTL with protocol, and total length.
        n_ip_fixed = {tpfb_pkg::IP_VER_IHL, 8'h00} + {tpfb_pkg::IP_TTL, tpfb_pkg::PROTO_TCP}
                   + (syn_in ? tpfb_pkg::IP_LEN_SYN : tpfb_pkg::IP_LEN_PLAIN);
        // Pseudo-header protocol and length, sequence, offset/flags, window, option.
        n_tcp_fixed = {9'h000, tpfb_pkg::PROTO_TCP}
                    + {1'b0, (syn_in ? tpfb_pkg::TCP_LEN_SYN : tpfb_pkg::TCP_LEN_PLAIN)}
                    + {1'b0, tpfb_pkg::TCP_SEQ[15:0]}
                    + {1'b0, (syn_in ? tpfb_pkg::DOFF_SYN : tpfb_pkg::DOFF_PLAIN),
                       6'b000000, i_probe.flag_bits}
                    + {1'b0, tpfb_pkg::TCP_WINDOW}
                    + (syn_in ? ({1'b0, tpfb_pkg::MSS_KIND_LEN} + {1'b0, tpfb_pkg::TCP_MSS})
                              : 17'h00000);
    end

    // Stage 2: full sums.
    always_comb begin
        n_ip_sum  = {2'b00, r_addr_sum} + {4'h0, r_ip_fixed};
        n_tcp_sum = {2'b00, r_addr_sum} + {3'b000, r_port_sum} + {3'b000, r_tcp_fixed};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p1        <= i_probe;
            r_addr_sum  <= n_addr_sum;
            r_port_sum  <= n_port_sum;
            r_ip_fixed  <= n_ip_fixed;
            r_tcp_fixed <= n_tcp_fixed;
        end
        if (adv2) begin
            r_p2      <= r_p1;
            r_ip_sum  <= n_ip_sum;
            r_tcp_sum <= n_tcp_sum;
        end
        // Stage 3: fold and invert into the final checksums.
        if (adv3) begin
            r_s3.probe    <= r_p2;
            r_s3.ip_csum  <= f_fold_not(r_ip_sum);
            r_s3.tcp_csum <= f_fold_not(r_tcp_sum);
        end
    end

    assign o_out_valid = r_v3;
    assign o_frame     = r_s3;

    // A stalled result keeps its place and its contents.
    `TPFB_ASSERT_NEXT(a_s3_holds, r_v3 && !i_out_ready, r_v3 && $stable(r_s3))
    // The pipeline never drops a full stage while the next one is stalled.
    `TPFB_ASSERT_NEXT(a_s2_holds, r_v2 && r_v3 && !i_out_ready, r_v2)

endmodule

`default_nettype wire

// ===== hw/rtl/tpfb_serializer.sv =====
// ----------------------------------------------------------------------------
// tpfb_serializer
// Holds one finished frame and sends it as fifteen 32-bit beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_probe_frame_builder_assert.svh"

module tpfb_serializer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tpfb_pkg::t_cfg   i_cfg,
    input  wire logic             i_frame_valid,
    output logic                  o_frame_ready,
    input  wire tpfb_pkg::t_frame i_frame,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [31:0]           o_frame_word,
    output logic                  o_word_last
);

    logic             r_busy;
    logic [3:0]       r_cnt;
    tpfb_pkg::t_frame r_frame;
    logic             r_valid;
    logic [31:0]      r_word;
    logic             r_last;

    logic             load_en;
    logic             take;
    tpfb_pkg::t_frame sel_frame;
    logic [3:0]       sel_idx;
    logic [31:0]      word;

    // Frame word at a given position. The 14-byte Ethernet header leaves the
    // IP and TCP fields straddling word boundaries.
    function automatic logic [31:0] f_word(input logic [3:0] idx,
                                           input tpfb_pkg::t_frame fr,
                                           input tpfb_pkg::t_cfg cfg);
        logic syn;
        logic [31:0] w;
        syn = fr.probe.flag_bits[tpfb_pkg::FLAG_SYN_BIT];
        case (idx)
            4'd0:  w = cfg.next_hop_mac[47:16];
            4'd1:  w = {cfg.next_hop_mac[15:0], cfg.own_mac[47:32]};
            4'd2:  w = cfg.own_mac[31:0];
            4'd3:  w = {tpfb_pkg::ETHERTYPE_IPV4, tpfb_pkg::IP_VER_IHL, 8'h00};
            4'd4:  w = {(syn ? tpfb_pkg::IP_LEN_SYN : tpfb_pkg::IP_LEN_PLAIN), 16'h0000};
            4'd5:  w = {16'h0000, tpfb_pkg::IP_TTL, tpfb_pkg::PROTO_TCP};
            4'd6:  w = {fr.ip_csum, cfg.own_ip[31:16]};
            4'd7:  w = {cfg.own_ip[15:0], fr.probe.target_ip[31:16]};
            4'd8:  w = {fr.probe.target_ip[15:0], fr.probe.local_port};
            4'd9:  w = {fr.probe.remote_port, tpfb_pkg::TCP_SEQ[31:16]};
            4'd10: w = {tpfb_pkg::TCP_SEQ[15:0], 16'h0000};
            4'd11: w = {16'h0000, (syn ? tpfb_pkg::DOFF_SYN : tpfb_pkg::DOFF_PLAIN), 4'h0,
                        2'b00, fr.probe.flag_bits};
            4'd12: w = {tpfb_pkg::TCP_WINDOW, fr.tcp_csum};
            4'd13: w = syn ? {16'h0000, tpfb_pkg::MSS_KIND_LEN} : 32'h0000_0000;
            4'd14: w = syn ? {tpfb_pkg::TCP_MSS, 16'h0000} : 32'h0000_0000;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

    // The output register loads when it is empty or its beat is taken.
    assign load_en       = !r_valid || i_ready;
    assign o_frame_ready = load_en && !r_busy;
    assign take          = o_frame_ready && i_frame_valid;

    // A new frame sends its first word straight away.
    assign sel_frame = r_busy ? r_frame : i_frame;
    assign sel_idx   = r_busy ? r_cnt : 4'd0;
    assign word      = f_word(sel_idx, sel_frame, i_cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= 4'd0;
            r_valid <= 1'b0;
        end else if (load_en) begin
            if (r_busy) begin
                r_valid <= 1'b1;
                r_cnt   <= r_cnt + 4'd1;
                r_busy  <= (r_cnt != tpfb_pkg::LAST_WORD);
            end else if (i_frame_valid) begin
                r_valid <= 1'b1;
                r_cnt   <= 4'd1;
                r_busy  <= 1'b1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (take) r_frame <= i_frame;
        if (load_en) begin
            r_word <= word;
            r_last <= r_busy && (r_cnt == tpfb_pkg::LAST_WORD);
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_word = r_word;
    assign o_word_last  = r_valid && r_last;

    // The final beat leaves the serializer free for the next frame.
    `TPFB_ASSERT_SAME(a_last_idle, r_valid && r_last, !r_busy)
    // Any other beat belongs to a frame still in progress.
    `TPFB_ASSERT_SAME(a_mid_busy, r_valid && !r_last, r_busy)

endmodule

`default_nettype wire

// ===== hw/rtl/tcp_probe_frame_builder.sv =====
// ----------------------------------------------------------------------------
// tcp_probe_frame_builder
// Builds a 60-byte Ethernet/IPv4/TCP probe frame from one request.
// ----------------------------------------------------------------------------
// Each accepted request becomes fifteen 32-bit beats on the output channel,
// first frame byte in bits 31..24 and o_word_last high on the fifteenth beat.
// Checksums are computed in a three-stage pipeline, and each frame then goes
// through the serializer's output register. The serializer sends one beat per
// cycle while i_ready is high and takes no new frame before the last beat of
// the current one has been loaded; up to three further requests wait in the
// checksum pipeline while a frame is being sent. The MAC addresses and the
// source IP are APB registers at byte addresses 0x00, 0x08 and 0x10, all zero
// after reset, and should be written only while no frame is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcp_probe_frame_builder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tpfb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tpfb_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tpfb_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [31:0]                   i_target_ip,
    input  wire logic [15:0]                   i_local_port,
    input  wire logic [15:0]                   i_remote_port,
    input  wire logic [5:0]                    i_flag_bits,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [31:0]                        o_frame_word,
    output logic                               o_word_last
);

    tpfb_pkg::t_cfg   cfg;
    tpfb_pkg::t_probe probe;
    tpfb_pkg::t_frame frame;
    logic             frame_valid;
    logic             frame_ready;

    assign probe.target_ip   = i_target_ip;
    assign probe.local_port  = i_local_port;
    assign probe.remote_port = i_remote_port;
    assign probe.flag_bits   = i_flag_bits;

    // Configuration registers.
    tpfb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Checksum pipeline.
    tpfb_csum_pipe u_csum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_own_ip    (cfg.own_ip),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_probe     (probe),
        .o_out_valid (frame_valid),
        .i_out_ready (frame_ready),
        .o_frame     (frame)
    );

    // Word serializer and output register.
    tpfb_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_frame_valid (frame_valid),
        .o_frame_ready (frame_ready),
        .i_frame       (frame),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_word  (o_frame_word),
        .o_word_last   (o_word_last)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tcp_probe_frame_builder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_probe_frame_builder_tb
// Self-checking bench for the TCP probe frame builder.
// ----------------------------------------------------------------------------
// Probe requests go in on a valid/ready channel. Every output beat is compared
// with a frame that the bench builds itself from the request and its own copy
// of the MAC and IP registers. A short table of directed requests runs first
// under the reset register values. Two of its frames are typed in by hand, and
// a few rows are steered so that the IP or the TCP checksum comes out as zero.
// Random requests follow under several register settings, the all-zero and
// all-ones extremes among them. Both sides idle at random, and once the
// receiver holds off long enough for the request pipeline to back up.
// ----------------------------------------------------------------------------

module tcp_probe_frame_builder_tb;

    import tpfb_pkg::*;

    // Frame words in wire order, word 0 leftmost.
    typedef logic [0:14][31:0] t_frame_words;

    // Ways a request is adjusted so that one of its checksums ends up zero.
    typedef enum logic [1:0] {
        STEER_NONE,
        STEER_IP_ZERO,
        STEER_TCP_ZERO
    } t_csum_steer;

    typedef struct packed {
        t_probe       probe;
        t_csum_steer  steer;
        logic         typed;
        t_frame_words frame;
    } t_probe_row;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_beat;

    localparam logic [1:0] CFG_UNMAPPED   = 2'd3;
    localparam int         NUM_PHASES     = 5;
    localparam int         PHASE_ITEMS    = 64;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         IDLE_PERCENT   = 8;

    // Hand-built frames with every register at zero and a request of zeros, with SYN set in the second.
    localparam t_frame_words FRAME_PLAIN_ZERO = {
        32'h00000000, 32'h00000000, 32'h00000000, 32'h08004500, 32'h00280000,
        32'h00004006, 32'h7AD10000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00640000, 32'h00005000, 32'hFAF0B490, 32'h00000000, 32'h00000000
    };
    localparam t_frame_words FRAME_SYN_ZERO = {
        32'h00000000, 32'h00000000, 32'h00000000, 32'h08004500, 32'h002C0000,
        32'h00004006, 32'h7ACD0000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00640000, 32'h00006002, 32'hFAF09CD2, 32'h00000204, 32'h05B40000
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_valid;
    logic                 o_ready;
    logic [31:0]          i_target_ip;
    logic [15:0]          i_local_port;
    logic [15:0]          i_remote_port;
    logic [5:0]           i_flag_bits;
    logic                 o_valid;
    logic                 i_ready;
    logic [31:0]          o_frame_word;
    logic                 o_word_last;

    // Bench copy of the configuration registers.
    logic [47:0] own_mac_q;
    logic [47:0] next_hop_mac_q;
    logic [31:0] own_ip_q;

    t_beat beats_due [$];
    int    mismatches   = 0;
    logic  quiet_run    = 1'b0;
    logic  hold_request = 1'b0;
    int    hold_left    = 0;

    // Directed requests: extremes of every field, each flag alone and the
    // checksum-zero cases, all under the reset register values.
    t_probe_row probe_table [0:15] = '{
        '{'{32'h00000000, 16'h0000, 16'h0000, 6'h00}, STEER_NONE, 1'b1, FRAME_PLAIN_ZERO},
        '{'{32'h00000000, 16'h0000, 16'h0000, 6'h02}, STEER_NONE, 1'b1, FRAME_SYN_ZERO},
        '{'{32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 6'h3F}, STEER_NONE, 1'b0, '0},
        '{'{32'h00000000, 16'hFFFF, 16'h0000, 6'h3D}, STEER_NONE, 1'b0, '0},
        '{'{32'hFFFFFFFF, 16'h0000, 16'hFFFF, 6'h01}, STEER_NONE, 1'b0, '0},
        '{'{32'hC0A80001, 16'h0050, 16'h1F90, 6'h04}, STEER_NONE, 1'b0, '0},
        '{'{32'h0A000001, 16'h0016, 16'h01BB, 6'h08}, STEER_NONE, 1'b0, '0},
        '{'{32'h7F000001, 16'h8000, 16'h0001, 6'h10}, STEER_NONE, 1'b0, '0},
        '{'{32'h80000000, 16'h0001, 16'h8000, 6'h20}, STEER_NONE, 1'b0, '0},
        '{'{32'h55AA55AA, 16'h1234, 16'h0050, 6'h12}, STEER_NONE, 1'b0, '0},
        '{'{32'hAA55AA55, 16'h4321, 16'h0016, 6'h00}, STEER_IP_ZERO, 1'b0, '0},
        '{'{32'h01020304, 16'h0000, 16'h0050, 6'h02}, STEER_IP_ZERO, 1'b0, '0},
        '{'{32'h08080808, 16'h0000, 16'h0050, 6'h00}, STEER_TCP_ZERO, 1'b0, '0},
        '{'{32'h08080404, 16'h0000, 16'h01BB, 6'h02}, STEER_TCP_ZERO, 1'b0, '0},
        '{'{32'h00000001, 16'h0000, 16'h0000, 6'h3F}, STEER_NONE, 1'b0, '0},
        '{'{32'hFFFFFFFE, 16'h7FFF, 16'hFFFE, 6'h2D}, STEER_NONE, 1'b0, '0}
    };

    tcp_probe_frame_builder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_target_ip   (i_target_ip),
        .i_local_port  (i_local_port),
        .i_remote_port (i_remote_port),
        .i_flag_bits   (i_flag_bits),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_word  (o_frame_word),
        .o_word_last   (o_word_last)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Folds a one's-complement sum to 16 bits and inverts it.
    function automatic logic [15:0] fold_not(input logic [31:0] sum);
        while (sum[31:16] != 16'h0000) sum = sum[15:0] + sum[31:16];
        return ~sum[15:0];
    endfunction

    // Builds the 60-byte frame for one request from the register copy.
    function automatic t_frame_words build_frame(input t_probe p);
        logic [7:0]   fb [0:59];
        logic [31:0]  acc;
        logic [15:0]  tcp_len;
        logic         syn;
        t_frame_words w;
        int           i;
        syn     = p.flag_bits[FLAG_SYN_BIT];
        tcp_len = syn ? TCP_LEN_SYN : TCP_LEN_PLAIN;
        for (i = 0; i < 60; i++) fb[i] = 8'h00;

        // Ethernet header.
        for (i = 0; i < 6; i++) begin
            fb[i]     = next_hop_mac_q[47 - 8 * i -: 8];
            fb[6 + i] = own_mac_q[47 - 8 * i -: 8];
        end
        {fb[12], fb[13]} = ETHERTYPE_IPV4;

        // IPv4 header and its checksum.
        fb[14] = IP_VER_IHL;
        {fb[16], fb[17]} = syn ? IP_LEN_SYN : IP_LEN_PLAIN;
        fb[22] = IP_TTL;
        fb[23] = PROTO_TCP;
        for (i = 0; i < 4; i++) begin
            fb[26 + i] = own_ip_q[31 - 8 * i -: 8];
            fb[30 + i] = p.target_ip[31 - 8 * i -: 8];
        end
        acc = 32'h0;
        for (i = 14; i < 34; i += 2) acc += {16'h0000, fb[i], fb[i + 1]};
        {fb[24], fb[25]} = fold_not(acc);

        // TCP header, with the MSS option when SYN is set.
        {fb[34], fb[35]} = p.local_port;
        {fb[36], fb[37]} = p.remote_port;
        {fb[38], fb[39], fb[40], fb[41]} = TCP_SEQ;
        fb[46] = {(syn ? DOFF_SYN : DOFF_PLAIN), 4'h0};
        fb[47] = {2'b00, p.flag_bits};
        {fb[48], fb[49]} = TCP_WINDOW;
        if (syn) begin
            {fb[54], fb[55]} = MSS_KIND_LEN;
            {fb[56], fb[57]} = TCP_MSS;
        end

        // Pseudo-header sum, then the TCP header itself.
        acc = own_ip_q[31:16] + own_ip_q[15:0] + p.target_ip[31:16] + p.target_ip[15:0]
            + PROTO_TCP + tcp_len;
        for (i = 34; i < 34 + int'(tcp_len); i += 2) acc += {16'h0000, fb[i], fb[i + 1]};
        {fb[50], fb[51]} = fold_not(acc);

        for (i = 0; i < 15; i++) begin
            w[i] = {fb[4 * i], fb[4 * i + 1], fb[4 * i + 2], fb[4 * i + 3]};
        end
        return w;
    endfunction

    // Picks the low half of the address or the source port so that the chosen
    // checksum comes out as zero: a field of zero leaves the complement of the
    // folded sum, and adding that back makes the sum all ones.
    function automatic t_probe steer_checksum(input t_probe p, input t_csum_steer steer);
        t_frame_words w;
        case (steer)
            STEER_IP_ZERO: begin
                p.target_ip[15:0] = 16'h0000;
                w = build_frame(p);
                p.target_ip[15:0] = w[6][31:16];
            end
            STEER_TCP_ZERO: begin
                p.local_port = 16'h0000;
                w = build_frame(p);
                p.local_port = w[12][15:0];
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    // Register write over the configuration port; the copy follows the write.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_OWN_MAC:      own_mac_q      = value[47:0];
            CFG_NEXT_HOP_MAC: next_hop_mac_q = value[47:0];
            CFG_OWN_IP:       own_ip_q       = value[31:0];
            default: begin
            end
        endcase
    endtask

    // Offers one request and queues its fifteen beats once it is taken.
    // Called at a falling edge and returns at one.
    task automatic offer_probe(input t_probe p, input t_frame_words frame);
        int k;
        while (!quiet_run && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_target_ip   <= p.target_ip;
        i_local_port  <= p.local_port;
        i_remote_port <= p.remote_port;
        i_flag_bits   <= p.flag_bits;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        for (k = 0; k < 15; k++) beats_due.push_back('{frame[k], k == 14});
        @(negedge i_clk);
    endtask

    // Waits until every queued beat has arrived.
    task automatic drain_frames();
        while (beats_due.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet_run || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Compare every output beat with the oldest expected one.
    always @(posedge i_clk) begin
        t_beat due;
        if (i_rst_n && o_valid && i_ready) begin
            if (beats_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got word %h last %b",
                         $time, o_frame_word, o_word_last);
                mismatches++;
            end else begin
                due = beats_due.pop_front();
                if (o_frame_word !== due.word) begin
                    $display("%0t: frame word expected %h, got %h",
                             $time, due.word, o_frame_word);
                    mismatches++;
                end
                if (o_word_last !== due.last) begin
                    $display("%0t: last flag expected %b, got %b",
                             $time, due.last, o_word_last);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        t_probe      p;
        t_csum_steer steer;
        int          row;
        int          phase;
        int          n;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_valid        = 1'b0;
        i_target_ip    = '0;
        i_local_port   = '0;
        i_remote_port  = '0;
        i_flag_bits    = '0;
        own_mac_q      = '0;
        next_hop_mac_q = '0;
        own_ip_q       = '0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table under the reset register values.
        for (row = 0; row < $size(probe_table); row++) begin
            p = steer_checksum(probe_table[row].probe, probe_table[row].steer);
            offer_probe(p, probe_table[row].typed ? probe_table[row].frame : build_frame(p));
        end
        i_valid <= 1'b0;

        // Random requests under several register settings.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_frames();
            case (phase)
                0: begin
                    // All ones, with bits above each register's width set.
                    write_reg(CFG_OWN_MAC, '1);
                    write_reg(CFG_NEXT_HOP_MAC, '1);
                    write_reg(CFG_OWN_IP, '1);
                    write_reg(CFG_UNMAPPED, {$urandom, $urandom});
                end
                1: begin
                    write_reg(CFG_OWN_MAC, '0);
                    write_reg(CFG_NEXT_HOP_MAC, '0);
                    write_reg(CFG_OWN_IP, '0);
                    write_reg(CFG_UNMAPPED, '1);
                end
                default: begin
                    write_reg(CFG_OWN_MAC, {$urandom, $urandom});
                    write_reg(CFG_NEXT_HOP_MAC, {$urandom, $urandom});
                    write_reg(CFG_OWN_IP, {$urandom, $urandom});
                end
            endcase
            quiet_run = (phase == 2);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Hold the receiver off while requests keep coming.
                if (phase == 1 && n == 8) hold_request = 1'b1;
                case ($urandom_range(7))
                    0:       p.target_ip = '1;
                    1:       p.target_ip = '0;
                    default: p.target_ip = $urandom;
                endcase
                p.local_port  = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
                p.remote_port = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
                p.flag_bits   = 6'($urandom_range(63));
                case ($urandom_range(9))
                    0:       steer = STEER_IP_ZERO;
                    1:       steer = STEER_TCP_ZERO;
                    default: steer = STEER_NONE;
                endcase
                p = steer_checksum(p, steer);
                offer_probe(p, build_frame(p));
            end
            i_valid <= 1'b0;
        end
        quiet_run = 1'b0;

        drain_frames();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tcp_probe_frame_builder: match");
        end else begin
            $display("tcp_probe_frame_builder: mismatch");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("tcp_probe_frame_builder: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tpfb_pkg.sv
hw/rtl/tpfb_cfg_regs.sv
hw/rtl/tpfb_csum_pipe.sv
hw/rtl/tpfb_serializer.sv
hw/rtl/tcp_probe_frame_builder.sv
tb/sv/tcp_probe_frame_builder_tb.sv
